### rtl/sclp_pkg.sv
// shared constants, types and keyword list for the serial command line parser
package sclp_pkg;

    localparam int MAX_FIELDS    = 5;
    localparam int FIELD_CHARS   = 10;
    localparam int KEYWORD_COUNT = 17;
    localparam int LINE_CHARS    = 60;

    localparam int TABLE_SIZE  = 17;
    localparam int KW_N        = (KEYWORD_COUNT < TABLE_SIZE) ? KEYWORD_COUNT : TABLE_SIZE;
    localparam int KW_CHARS    = 4;
    localparam int CH_W        = 7;
    localparam int CODE_W      = 5;

    localparam int STORE_DEPTH = MAX_FIELDS * FIELD_CHARS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FIELD_IDX_W = $clog2(MAX_FIELDS);
    localparam int FIELD_CNT_W = $clog2(MAX_FIELDS + 1);
    localparam int LEN_W       = $clog2(FIELD_CHARS + 1);
    localparam int CHAR_IDX_W  = $clog2(FIELD_CHARS);
    localparam int KEPT_W      = $clog2(LINE_CHARS + 1);
    localparam int CI_W        = $clog2(KW_CHARS);

    typedef struct packed {
        logic [2:0]               len;
        logic [KW_CHARS*CH_W-1:0] text;
    } kw_t;

    typedef struct packed {
        logic                     start;
        logic [LEN_W-1:0]         len;
        logic [KW_CHARS*CH_W-1:0] text;
    } match_req_t;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [CODE_W-1:0] code;
    } match_rsp_t;

    function automatic logic [KW_CHARS*CH_W-1:0] pack4(
        input logic [7:0] c0, input logic [7:0] c1,
        input logic [7:0] c2, input logic [7:0] c3);
        return {c3[CH_W-1:0], c2[CH_W-1:0], c1[CH_W-1:0], c0[CH_W-1:0]};
    endfunction

    // command keywords, first character in the low bits
    function automatic kw_t kw_entry(input logic [CODE_W-1:0] idx);
        kw_t kw;
        case (idx)
            5'd0:    kw = '{len: 3'd4, text: pack4("s", "h", "o", "w")};
            5'd1:    kw = '{len: 3'd4, text: pack4("h", "e", "l", "p")};
            5'd2:    kw = '{len: 3'd3, text: pack4("s", "l", "b", 8'd0)};
            5'd3:    kw = '{len: 3'd3, text: pack4("g", "l", "b", 8'd0)};
            5'd4:    kw = '{len: 3'd4, text: pack4("s", "l", "b", "p")};
            5'd5:    kw = '{len: 3'd4, text: pack4("g", "l", "b", "p")};
            5'd6:    kw = '{len: 3'd3, text: pack4("s", "l", "c", 8'd0)};
            5'd7:    kw = '{len: 3'd3, text: pack4("g", "l", "c", 8'd0)};
            5'd8:    kw = '{len: 3'd4, text: pack4("s", "l", "c", "p")};
            5'd9:    kw = '{len: 3'd4, text: pack4("g", "l", "c", "p")};
            5'd10:   kw = '{len: 3'd4, text: pack4("s", "l", "e", "d")};
            5'd11:   kw = '{len: 3'd4, text: pack4("g", "l", "e", "d")};
            5'd12:   kw = '{len: 3'd4, text: pack4("s", "r", "t", "c")};
            5'd13:   kw = '{len: 3'd4, text: pack4("g", "t", "e", "m")};
            5'd14:   kw = '{len: 3'd4, text: pack4("g", "h", "u", "m")};
            5'd15:   kw = '{len: 3'd4, text: pack4("s", "m", "o", "d")};
            5'd16:   kw = '{len: 3'd4, text: pack4("g", "m", "o", "d")};
            default: kw = '{len: 3'd0, text: '0};
        endcase
        return kw;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [FIELD_IDX_W-1:0] f, input logic [CHAR_IDX_W-1:0] c);
        return ADDR_W'(int'(f) * FIELD_CHARS + int'(c));
    endfunction

endpackage

### rtl/sclp_store.sv
// field character store, one write and one registered read port
module sclp_store
    import sclp_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [CH_W-1:0]   wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [CH_W-1:0]   rd_data
);

    logic [CH_W-1:0] mem_reg [STORE_DEPTH];
    logic [CH_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/sclp_kw_match.sv
// keyword matcher: one keyword compared per cycle against the command field
module sclp_kw_match
    import sclp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  match_req_t req,
    output match_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              found_reg, found_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [CODE_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [KW_CHARS*CH_W-1:0] text_reg, text_next;

    kw_t  kw;
    logic hit;

    // shared compare unit
    always_comb
    begin
        logic [CH_W-1:0] ch;
        kw  = kw_entry(idx_reg);
        hit = (LEN_W'(kw.len) == len_reg) && (len_reg != '0);
        for (int k = 0; k < KW_CHARS; k++)
        begin
            ch = text_reg[k*CH_W +: CH_W];
            if (ch >= 7'd65 && ch <= 7'd90)
            begin
                ch = ch + 7'd32;
            end
            if (LEN_W'(k) < len_reg && ch != kw.text[k*CH_W +: CH_W])
            begin
                hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        code_next  = code_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        text_next  = text_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            found_next = 1'b0;
            code_next  = '0;
            idx_next   = '0;
            len_next   = req.len;
            text_next  = req.text;
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                found_next = 1'b1;
                code_next  = idx_reg;
            end
            if (idx_reg == CODE_W'(KW_N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            code_reg  <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            code_reg  <= code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        len_reg  <= len_next;
        text_reg <= text_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.found = found_reg;
    assign rsp.code  = code_reg;

endmodule

### rtl/serial_command_line_parser.sv
// serial command line parser top level: line state, sequencer and result register
//
// usage
//   input channel (in_valid / in_ready / rx_byte) takes one received byte per item.
//   bytes 33 to 127 are kept, split at '=' and ',' into fields; other bytes are dropped.
//   an ordinary byte is taken and causes no result; in_ready stays high.
//   lf or cr ends the line: in_ready drops while the line is worked off.
//   the command field, when 1 to 4 chars long, is read back from the field store a char
//   at a time, then the keyword matcher checks one keyword a cycle up to the verdict item.
//   the verdict is followed by the parameter chars of fields 1 and up, each read
//   back through the field store read port, one field after the other.
//   last_of_run marks the final item of a line end; then the line state is cleared.
//   a stalled receiver holds the result register; the sequencer waits, nothing is lost.
//   the last result may still wait while new bytes of the next line are taken.
//   reset clears line state and the result valid flag; the field store needs no clear.
module serial_command_line_parser
    import sclp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             result_kind,
    output logic [4:0]       command_code,
    output logic             parse_error,
    output logic [2:0]       field_number,
    output logic [6:0]       field_char,
    output logic             last_of_run
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CMDRD  = 3'd1;
    localparam logic [2:0] ST_CMDCAP = 3'd2;
    localparam logic [2:0] ST_MATCH  = 3'd3;
    localparam logic [2:0] ST_VERD   = 3'd4;
    localparam logic [2:0] ST_NEXT   = 3'd5;
    localparam logic [2:0] ST_CHAR   = 3'd6;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_FIRST = 8'd33;
    localparam logic [7:0] CH_LAST  = 8'd127;
    localparam logic [7:0] CH_EQ    = 8'd61;
    localparam logic [7:0] CH_COMMA = 8'd44;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_CHAR    = 1'b1;

    logic [2:0]             state_reg, state_next;
    logic [LEN_W-1:0]       lens_reg [MAX_FIELDS];
    logic [LEN_W-1:0]       lens_next [MAX_FIELDS];
    logic [FIELD_CNT_W-1:0] cur_reg, cur_next;
    logic [KEPT_W-1:0]      kept_reg, kept_next;
    logic [CI_W-1:0]        ci_reg, ci_next;
    logic [FIELD_IDX_W-1:0] f_reg, f_next;
    logic [LEN_W-1:0]       c_reg, c_next;
    logic [KW_CHARS*CH_W-1:0] cmd_text_reg, cmd_text_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              kind_reg, kind_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              err_reg, err_next;
    logic [2:0]        fnum_reg, fnum_next;
    logic [CH_W-1:0]   char_reg, char_next;
    logic              last_reg, last_next;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CH_W-1:0]   rd_data;
    match_req_t        mreq;
    match_rsp_t        mrsp;

    logic                   out_free;
    logic [FIELD_IDX_W-1:0] cur_idx;
    logic                   any_param;
    logic                   later_any;

    assign out_free = !out_valid_reg || out_ready;
    assign cur_idx  = cur_reg[FIELD_IDX_W-1:0];
    assign in_ready = (state_reg == ST_IDLE);

    // does any parameter field (or any field after the current one) hold chars
    always_comb
    begin
        any_param = 1'b0;
        later_any = 1'b0;
        for (int g = 1; g < MAX_FIELDS; g++)
        begin
            if (lens_reg[g] != '0)
            begin
                any_param = 1'b1;
                if (FIELD_IDX_W'(g) > f_reg)
                begin
                    later_any = 1'b1;
                end
            end
        end
    end

    sclp_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rx_byte[CH_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sclp_kw_match u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        lens_next      = lens_reg;
        cur_next       = cur_reg;
        kept_next      = kept_reg;
        ci_next        = ci_reg;
        f_next         = f_reg;
        c_next         = c_reg;
        cmd_text_next  = cmd_text_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        code_next      = code_reg;
        err_next       = err_reg;
        fnum_next      = fnum_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        mreq.start     = 1'b0;
        mreq.len       = lens_reg[0];
        mreq.text      = cmd_text_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (rx_byte == CH_LF || rx_byte == CH_CR)
                    begin
                        ci_next = '0;
                        if (lens_reg[0] != '0 && lens_reg[0] <= LEN_W'(KW_CHARS))
                        begin
                            state_next = ST_CMDRD;
                        end
                        else
                        begin
                            // command field cannot match any keyword
                            mreq.start = 1'b1;
                            state_next = ST_MATCH;
                        end
                    end
                    else if (rx_byte >= CH_FIRST && rx_byte <= CH_LAST
                             && kept_reg < KEPT_W'(LINE_CHARS))
                    begin
                        kept_next = kept_reg + 1'b1;
                        if (cur_reg < FIELD_CNT_W'(MAX_FIELDS))
                        begin
                            if (rx_byte == CH_EQ || rx_byte == CH_COMMA)
                            begin
                                cur_next = cur_reg + 1'b1;
                            end
                            else if (lens_reg[cur_idx] < LEN_W'(FIELD_CHARS))
                            begin
                                wr_en   = 1'b1;
                                wr_addr = store_addr(cur_idx,
                                                     lens_reg[cur_idx][CHAR_IDX_W-1:0]);
                                lens_next[cur_idx] = lens_reg[cur_idx] + 1'b1;
                            end
                        end
                    end
                end
            end
            ST_CMDRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = store_addr('0, CHAR_IDX_W'(ci_reg));
                state_next = ST_CMDCAP;
            end
            ST_CMDCAP:
            begin
                cmd_text_next[ci_reg*CH_W +: CH_W] = rd_data;
                ci_next = ci_reg + 1'b1;
                if (LEN_W'(ci_reg) + LEN_W'(1) == lens_reg[0])
                begin
                    // hand over the text including the char captured now
                    mreq.start = 1'b1;
                    mreq.text  = cmd_text_next;
                    state_next = ST_MATCH;
                end
                else
                begin
                    state_next = ST_CMDRD;
                end
            end
            ST_MATCH:
            begin
                if (mrsp.done)
                begin
                    state_next = ST_VERD;
                end
            end
            ST_VERD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_VERDICT;
                    code_next      = mrsp.found ? mrsp.code : '0;
                    err_next       = !mrsp.found;
                    fnum_next      = '0;
                    char_next      = '0;
                    last_next      = !any_param;
                    f_next         = FIELD_IDX_W'(1);
                    c_next         = '0;
                    state_next     = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (c_reg < lens_reg[f_reg])
                begin
                    rd_en      = 1'b1;
                    rd_addr    = store_addr(f_reg, c_reg[CHAR_IDX_W-1:0]);
                    state_next = ST_CHAR;
                end
                else if (f_reg == FIELD_IDX_W'(MAX_FIELDS - 1))
                begin
                    // line done: clear line state
                    for (int g = 0; g < MAX_FIELDS; g++)
                    begin
                        lens_next[g] = '0;
                    end
                    cur_next   = '0;
                    kept_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    f_next = f_reg + 1'b1;
                    c_next = '0;
                end
            end
            ST_CHAR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_CHAR;
                    code_next      = '0;
                    err_next       = 1'b0;
                    fnum_next      = 3'(f_reg);
                    char_next      = rd_data;
                    last_next      = (c_reg + 1'b1 == lens_reg[f_reg]) && !later_any;
                    c_next         = c_reg + 1'b1;
                    state_next     = ST_NEXT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            kept_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int g = 0; g < MAX_FIELDS; g++)
            begin
                lens_reg[g] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            kept_reg      <= kept_next;
            out_valid_reg <= out_valid_next;
            lens_reg      <= lens_next;
        end
    end

    // payload and sequencer working registers
    always_ff @(posedge clk)
    begin
        ci_reg       <= ci_next;
        f_reg        <= f_next;
        c_reg        <= c_next;
        cmd_text_reg <= cmd_text_next;
        kind_reg     <= kind_next;
        code_reg     <= code_next;
        err_reg      <= err_next;
        fnum_reg     <= fnum_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign command_code = code_reg;
    assign parse_error  = err_reg;
    assign field_number = fnum_reg;
    assign field_char   = char_reg;
    assign last_of_run  = last_reg;

`ifndef NO_ASSERTIONS
    // field pointer never runs past the field count
    assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= FIELD_CNT_W'(MAX_FIELDS))
        else $error("field pointer out of range");

    // kept byte count stays within the line limit
    assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= KEPT_W'(LINE_CHARS))
        else $error("kept count out of range");

    // a verdict is presented right after the verdict state loads it
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VERD && out_free) |=> (out_valid && result_kind == KIND_VERDICT))
        else $error("verdict not presented");

    // the matcher only reports while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mrsp.done |-> (state_reg == ST_MATCH))
        else $error("matcher done outside match state");
`endif

endmodule

### bench/serial_command_line_parser_checker.sv
// result checker for the serial command line parser: line predictor and result compare
`timescale 1ns / 1ps

module serial_command_line_parser_checker
    import sclp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       result_kind,
    input  logic [4:0] command_code,
    input  logic       parse_error,
    input  logic [2:0] field_number,
    input  logic [6:0] field_char,
    input  logic       last_of_run,
    output int         failures,
    output int         pending,
    output int         verdicts,
    output int         rejects,
    output int         param_chars
);

    localparam logic [7:0] LINE_FEED       = 8'd10;
    localparam logic [7:0] CARRIAGE_RETURN = 8'd13;
    localparam logic [7:0] FIRST_KEPT      = 8'd33;
    localparam logic [7:0] LAST_KEPT       = 8'd127;
    localparam logic [7:0] SEP_EQUALS      = "=";
    localparam logic [7:0] SEP_COMMA       = ",";
    localparam logic [7:0] CASE_OFFSET     = 8'd32;
    localparam logic       KIND_VERDICT    = 1'b0;
    localparam logic       KIND_CHAR       = 1'b1;
    localparam logic [4:0] CODE_NONE       = 5'd0;

    typedef struct packed {
        logic       kind;
        logic [4:0] code;
        logic       err;
        logic [2:0] fnum;
        logic [6:0] ch;
        logic       last;
    } reply_t;

    // keyword order gives the command code
    string command_words [KW_N] = '{
        "show", "help", "slb", "glb", "slbp", "glbp", "slc", "glc", "slcp",
        "glcp", "sled", "gled", "srtc", "gtem", "ghum", "smod", "gmod"
    };

    logic [6:0]  line_store [STORE_DEPTH];
    int unsigned part_len [MAX_FIELDS];
    int unsigned part_idx;
    int unsigned kept_total;
    reply_t      expected_replies [$];

    function automatic void clear_line_state();
        foreach (line_store[i]) line_store[i] = '0;
        foreach (part_len[i]) part_len[i] = 0;
        part_idx   = 0;
        kept_total = 0;
    endfunction

    // whole, case-folded match of the command field; -1 when nothing fits
    function automatic int lookup_command();
        int         hit;
        int         len;
        bit         same;
        logic [7:0] c;
        hit = -1;
        len = part_len[0];
        for (int i = 0; i < KW_N; i++)
        begin
            if (len == 0 || command_words[i].len() != len)
                continue;
            same = 1'b1;
            for (int k = 0; k < len; k++)
            begin
                c = {1'b0, line_store[k]};
                if (c >= "A" && c <= "Z")
                    c = c + CASE_OFFSET;
                if (c != command_words[i][k])
                    same = 1'b0;
            end
            if (same)
                hit = i;
        end
        return hit;
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        reply_t r;
        int     code;
        int     total;
        int     sent;
        if (b == LINE_FEED || b == CARRIAGE_RETURN)
        begin
            code  = lookup_command();
            total = 0;
            for (int f = 1; f < MAX_FIELDS; f++)
                total += part_len[f];
            r      = '0;
            r.kind = KIND_VERDICT;
            r.err  = (code < 0);
            r.code = (code < 0) ? CODE_NONE : 5'(code);
            r.last = (total == 0);
            expected_replies.push_back(r);
            sent = 0;
            for (int f = 1; f < MAX_FIELDS; f++)
            begin
                for (int ci = 0; ci < part_len[f]; ci++)
                begin
                    sent++;
                    r      = '0;
                    r.kind = KIND_CHAR;
                    r.fnum = 3'(f);
                    r.ch   = line_store[f * FIELD_CHARS + ci];
                    r.last = (sent == total);
                    expected_replies.push_back(r);
                end
            end
            clear_line_state();
        end
        else if (b >= FIRST_KEPT && b <= LAST_KEPT && kept_total < LINE_CHARS)
        begin
            kept_total++;
            if (part_idx < MAX_FIELDS)
            begin
                if (b == SEP_EQUALS || b == SEP_COMMA)
                begin
                    part_idx++;
                end
                else if (part_len[part_idx] < FIELD_CHARS)
                begin
                    line_store[part_idx * FIELD_CHARS + part_len[part_idx]] = b[6:0];
                    part_len[part_idx]++;
                end
            end
        end
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, what, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            clear_line_state();
            expected_replies.delete();
            pending <= 0;
        end
        else
        begin
            // compare before predicting: a byte taken now cannot cause this result
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t ns: result with none expected, expected nothing, actual %s",
                             $time, "an item");
                    $display("    kind %0d code %0d err %0d field %0d char %0d last %0d",
                             result_kind, command_code, parse_error,
                             field_number, field_char, last_of_run);
                    failures++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("result_kind", 8'(want.kind), 8'(result_kind));
                    check_field("command_code", 8'(want.code), 8'(command_code));
                    check_field("parse_error", 8'(want.err), 8'(parse_error));
                    check_field("field_number", 8'(want.fnum), 8'(field_number));
                    check_field("field_char", 8'(want.ch), 8'(field_char));
                    check_field("last_of_run", 8'(want.last), 8'(last_of_run));
                    if (want.kind == KIND_VERDICT)
                    begin
                        verdicts++;
                        if (want.err)
                            rejects++;
                    end
                    else
                    begin
                        param_chars++;
                    end
                end
            end
            if (in_valid && in_ready)
                take_byte(rx_byte);
            pending <= expected_replies.size();
        end
    end

endmodule

### bench/serial_command_line_parser_tb.sv
// testbench top for the serial command line parser: byte stimulus, receiver stalls, verdict
`timescale 1ns / 1ps

module serial_command_line_parser_tb;
    import sclp_pkg::*;

    // byte values with a meaning to the parser
    localparam logic [7:0] LINE_FEED       = 8'd10;
    localparam logic [7:0] CARRIAGE_RETURN = 8'd13;
    localparam logic [7:0] SPACE           = 8'd32;
    localparam logic [7:0] FIRST_KEPT      = 8'd33;
    localparam logic [7:0] LAST_KEPT       = 8'd127;
    localparam logic [7:0] SEP_EQUALS      = "=";
    localparam logic [7:0] SEP_COMMA       = ",";
    localparam logic [7:0] FILLER          = "#";
    localparam logic [7:0] CASE_OFFSET     = 8'd32;

    // shapes of generated lines
    localparam int SHAPE_ANY  = 0;
    localparam int SHAPE_FULL = 1;
    localparam int SHAPE_LONG = 2;

    // run sizing
    localparam int ITEM_TARGET    = 350;
    localparam int HOLD_START     = 130;
    localparam int QUIET_TAIL     = 70;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 2000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic       result_kind;
    logic [4:0] command_code;
    logic       parse_error;
    logic [2:0] field_number;
    logic [6:0] field_char;
    logic       last_of_run;

    int failures;
    int pending;
    int verdicts;
    int rejects;
    int param_chars;

    // stimulus bookkeeping
    int         bytes_sent;
    int         line_ends_sent;
    int         word_turn;
    int         quiet_cycles;
    bit         src_idle;
    bit         sink_idle;
    bit         hold_request;
    logic [7:0] line_buf [$];

    serial_command_line_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .command_code (command_code),
        .parse_error  (parse_error),
        .field_number (field_number),
        .field_char   (field_char),
        .last_of_run  (last_of_run)
    );

    // watches both channels, predicts every line end and counts mismatches
    serial_command_line_parser_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .command_code (command_code),
        .parse_error  (parse_error),
        .field_number (field_number),
        .field_char   (field_char),
        .last_of_run  (last_of_run),
        .failures     (failures),
        .pending      (pending),
        .verdicts     (verdicts),
        .rejects      (rejects),
        .param_chars  (param_chars)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // any byte that never ends a line: spaces, controls, high bytes or kept chars
    function automatic logic [7:0] noise_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == LINE_FEED || c == CARRIAGE_RETURN)
            c = SPACE;
        return c;
    endfunction

    function automatic logic [7:0] pick_separator();
        return ($urandom_range(0, 1) != 0) ? SEP_EQUALS : SEP_COMMA;
    endfunction

    // kept character that does not split the field
    function automatic logic [7:0] field_text_char();
        logic [7:0] c;
        c = 8'($urandom_range(FIRST_KEPT, LAST_KEPT));
        if (c == SEP_EQUALS || c == SEP_COMMA)
            c = FILLER;
        return c;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    // one line into line_buf: mostly keyword plus parameters, the rest noise,
    // broken keywords, surplus fields and over-long lines
    function automatic void build_line(input int shape);
        int         pick;
        int         fields;
        int         flen;
        int         wl;
        kw_t        kw;
        logic [7:0] c;
        pick = (shape == SHAPE_ANY) ? $urandom_range(0, 19) : 0;
        if (shape == SHAPE_LONG || pick >= 18)
        begin
            // from two under to fifteen over the kept-byte limit, separators included
            flen = $urandom_range(LINE_CHARS - 2, LINE_CHARS + 15);
            for (int i = 0; i < flen; i++)
                line_buf.push_back(($urandom_range(0, 5) == 0) ? pick_separator()
                                                               : field_text_char());
        end
        else if (pick >= 15)
        begin
            flen = $urandom_range(0, 12);
            for (int i = 0; i < flen; i++)
                line_buf.push_back(noise_byte());
        end
        else
        begin
            // keywords in turn so that every command shows up, random case
            kw = kw_entry(CODE_W'(word_turn % KW_N));
            word_turn++;
            wl = kw.len;
            if (pick >= 13)
                wl = ($urandom_range(0, 1) != 0) ? wl - 1 : wl + 1;
            for (int k = 0; k < wl; k++)
            begin
                if (k < kw.len)
                    c = {1'b0, kw.text[k * CH_W +: CH_W]};
                else
                    c = 8'($urandom_range("a", "z"));
                if ($urandom_range(0, 2) == 0 && c >= "a" && c <= "z")
                    c = c - CASE_OFFSET;
                line_buf.push_back(c);
            end
            if (shape == SHAPE_FULL)
                fields = MAX_FIELDS - 1;
            else if (pick == 12)
                fields = $urandom_range(MAX_FIELDS, MAX_FIELDS + 2);
            else
                fields = $urandom_range(0, MAX_FIELDS - 1);
            for (int f = 0; f < fields; f++)
            begin
                line_buf.push_back(pick_separator());
                flen = (shape == SHAPE_FULL) ? FIELD_CHARS
                                             : $urandom_range(0, FIELD_CHARS + 2);
                for (int i = 0; i < flen; i++)
                begin
                    if (shape != SHAPE_FULL && $urandom_range(0, 9) == 0)
                        line_buf.push_back(noise_byte());
                    line_buf.push_back(field_text_char());
                end
            end
        end
        // line end: lf, cr, or a cr lf pair which gives an extra empty verdict
        case ($urandom_range(0, 3))
            1: line_buf.push_back(CARRIAGE_RETURN);
            2:
            begin
                line_buf.push_back(CARRIAGE_RETURN);
                line_buf.push_back(LINE_FEED);
            end
            default: line_buf.push_back(LINE_FEED);
        endcase
    endfunction

    // offer one item from a falling edge, hold it until taken, then maybe pause
    task automatic send_byte(input logic [7:0] b);
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        if (b == LINE_FEED || b == CARRIAGE_RETURN)
            line_ends_sent++;
        @(negedge clk);
        if (src_idle && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    task automatic send_line_buf();
        while (line_buf.size() != 0)
            send_byte(line_buf.pop_front());
    endtask

    // receiver: random stall bursts, one long hold on request, none in the tail
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                // long hold so the result register fills and the input stalls
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (sink_idle && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog: ends the run when no item moves on either channel for too long
    initial quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // main sequence
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        rx_byte        = '0;
        src_idle       = 1'b1;
        sink_idle      = 1'b1;
        hold_request   = 1'b0;
        bytes_sent     = 0;
        line_ends_sent = 0;
        word_turn      = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty line, mixed-case keyword with dropped bytes (space,
        // high bytes, controls, zero), lowest and highest kept chars, an empty
        // field, then a cr lf pair, and an unknown command that still has parameters
        line_buf.push_back(LINE_FEED);
        push_text("sHoW");
        line_buf.push_back(SPACE);
        line_buf.push_back(8'h80);
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h09);
        line_buf.push_back(8'h00);
        push_text("=!");
        line_buf.push_back(LAST_KEPT);
        push_text(",,Z");
        line_buf.push_back(CARRIAGE_RETURN);
        line_buf.push_back(LINE_FEED);
        push_text("xyz=q");
        line_buf.push_back(LINE_FEED);
        send_line_buf();

        // random lines, starting with a long one near or past the line limit
        build_line(SHAPE_LONG);
        send_line_buf();
        while (bytes_sent < HOLD_START)
        begin
            build_line(SHAPE_ANY);
            send_line_buf();
        end

        // receiver holds off while two lines of the most results come in
        hold_request = 1'b1;
        build_line(SHAPE_FULL);
        build_line(SHAPE_FULL);
        send_line_buf();

        while (bytes_sent < ITEM_TARGET - QUIET_TAIL)
        begin
            build_line(SHAPE_ANY);
            send_line_buf();
        end

        // tail at full rate on both sides
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        while (bytes_sent < ITEM_TARGET)
        begin
            build_line(SHAPE_ANY);
            send_line_buf();
        end
        in_valid <= 1'b0;

        // drain every expected result, then let the block settle
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d bytes and %0d line ends: %0d verdicts (%0d rejected),",
                 bytes_sent, line_ends_sent, verdicts, rejects);
        $display("%0d parameter chars, a %0d-cycle receiver hold, over-long lines and fields",
                 param_chars, HOLD_CYCLES);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/sclp_pkg.sv
rtl/sclp_store.sv
rtl/sclp_kw_match.sv
rtl/serial_command_line_parser.sv
bench/serial_command_line_parser_checker.sv
bench/serial_command_line_parser_tb.sv
